// ===== rtl/nearest_least_loaded_gate_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gate allocator
// Clocked, reset-qualified property shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_LEAST_LOADED_GATE_ALLOCATOR_CORE_MACROS_SVH
`define NEAREST_LEAST_LOADED_GATE_ALLOCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NLLG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gate allocator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NLLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gate allocator assertion failed");

`endif

// ===== rtl/nllg_pkg.sv =====
// ----------------------------------------------------------------------------
// Gate allocator package
// Field widths, command codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package nllg_pkg;

  localparam int DIST_W      = 16;
  localparam int GATE_W      = 4;
  localparam int CFG_W       = 5;
  localparam int OCC_W       = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic [OCC_W-1:0] OCC_TOP = 8'hFF;

  // Request kinds carried on in_tuser.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch an accepted request and reset the search
    logic pref_step;  // advance the preferred-gate search
    logic scan;       // run the occupancy scan
    logic commit;     // write back the count and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pref_done;  // preferred gate is settled
    logic scan_done;  // best gate is settled
  } dp_status_t;

endpackage

// ===== rtl/nllg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nllg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nllg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Gate allocator controller
// Sequences one request at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module nllg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_cmd,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  nllg_pkg::dp_status_t status,
  output nllg_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREF,
    ST_SCAN,
    ST_REL_RD,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_cmd == nllg_pkg::CMD_RELEASE) ? ST_REL_RD : ST_PREF;
        end
      end
      ST_PREF: begin
        cmd.pref_step = 1'b1;
        if (status.pref_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_REL_RD: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/nllg_dpath.sv =====
// ----------------------------------------------------------------------------
// Gate allocator datapath
// Gate count register, preferred-gate search, occupancy scan and write-back.
// ----------------------------------------------------------------------------
module nllg_dpath #(
  parameter int MAX_GATES    = 16,
  parameter int GATE_SPACING = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [nllg_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                            in_cmd,
  input  logic [nllg_pkg::DIST_W-1:0]     in_point_distance,
  input  logic [nllg_pkg::GATE_W-1:0]     in_release_gate,
  input  nllg_pkg::ctrl_cmd_t             cmd,
  output nllg_pkg::dp_status_t            status,
  output logic [nllg_pkg::GATE_W-1:0]     res_chosen_gate,
  output logic                            res_got_preferred,
  output logic                            res_flag_error
);

  localparam int IDX_W  = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int TGT_W  = $clog2((2 ** nllg_pkg::DIST_W) + GATE_SPACING / 2);
  localparam int ACC_W  = $clog2(MAX_GATES * GATE_SPACING + 1);
  localparam int COST_W = $clog2(256 + MAX_GATES);
  localparam int OCC_W  = nllg_pkg::OCC_W;

  localparam logic [TGT_W-1:0] HALF_SP = TGT_W'(GATE_SPACING / 2);
  localparam logic [ACC_W-1:0] SPACING = ACC_W'(GATE_SPACING);

  logic [nllg_pkg::CFG_W-1:0] gate_count_r;
  logic [MAX_GATES-1:0]       valid_r;

  logic                       cmd_r;
  logic [TGT_W-1:0]           target_r;
  logic [ACC_W-1:0]           acc_r;
  logic [nllg_pkg::GATE_W-1:0] rel_r;
  logic [IDX_W-1:0]           pref_r;
  logic [IDX_W:0]             scan_idx_r;
  logic [IDX_W-1:0]           cmp_idx_r;
  logic                       cmp_vld_r;
  logic [IDX_W-1:0]           best_r;
  logic [COST_W-1:0]          best_cost_r;
  logic [OCC_W-1:0]           best_occ_r;
  logic                       rd_vld_r;

  logic [nllg_pkg::GATE_W-1:0] res_gate_r;
  logic                        res_pref_r;
  logic                        res_err_r;

  logic [IDX_W-1:0]  last_gate;
  logic [IDX_W-1:0]  rel_idx;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic [OCC_W-1:0]  rd_data;
  logic [OCC_W-1:0]  occ;
  logic [OCC_W-1:0]  wdata;
  logic              we;
  logic [IDX_W-1:0]  dist_gates;
  logic [COST_W-1:0] cost;
  logic              better;
  logic              issue_more;
  logic              rel_ok;

  // Index of the last gate in use; zero counts as one gate.
  always_comb begin
    if (gate_count_r == '0) begin
      last_gate = '0;
    end else if (32'(gate_count_r) > 32'(MAX_GATES)) begin
      last_gate = IDX_W'(MAX_GATES - 1);
    end else begin
      last_gate = IDX_W'(gate_count_r - nllg_pkg::CFG_W'(1));
    end
  end

  assign rel_idx = IDX_W'(rel_r);
  assign occ     = rd_vld_r ? rd_data : '0;

  always_comb begin
    dist_gates = (cmp_idx_r >= pref_r) ? (cmp_idx_r - pref_r) : (pref_r - cmp_idx_r);
    cost       = COST_W'(occ) + COST_W'(dist_gates);
    better     = cost < best_cost_r;
    issue_more = 32'(scan_idx_r) <= 32'(last_gate);
    rel_ok     = (32'(rel_r) <= 32'(last_gate)) && (occ != '0);
    raddr      = cmd.scan ? scan_idx_r[IDX_W-1:0] : rel_idx;
  end

  always_comb begin
    status.pref_done = (pref_r == last_gate) ||
                       (32'(target_r) < 32'(acc_r));
    status.scan_done = cmp_vld_r &&
                       ((better && (cost == '0)) || (cmp_idx_r == last_gate));
  end

  // Write-back: release decrements, allocate increments up to the top.
  always_comb begin
    if (cmd_r == nllg_pkg::CMD_RELEASE) begin
      we    = cmd.commit && rel_ok;
      waddr = rel_idx;
      wdata = occ - OCC_W'(1);
    end else begin
      we    = cmd.commit && (best_occ_r != nllg_pkg::OCC_TOP);
      waddr = best_r;
      wdata = best_occ_r + OCC_W'(1);
    end
  end

  nllg_ram #(
    .WIDTH (OCC_W),
    .DEPTH (MAX_GATES)
  ) u_occ_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_count_r <= nllg_pkg::CFG_W'(1);
      valid_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        gate_count_r <= cfg_wr_data;
      end
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= valid_r[raddr];

    if (cmd.capture) begin
      cmd_r       <= in_cmd;
      target_r    <= TGT_W'(in_point_distance) + HALF_SP;
      rel_r       <= in_release_gate;
      pref_r      <= '0;
      acc_r       <= SPACING;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      best_r      <= '0;
      best_cost_r <= '1;
      best_occ_r  <= '0;
    end

    if (cmd.pref_step && !status.pref_done) begin
      pref_r <= pref_r + IDX_W'(1);
      acc_r  <= acc_r + SPACING;
    end

    if (cmd.scan) begin
      cmp_vld_r <= issue_more;
      cmp_idx_r <= scan_idx_r[IDX_W-1:0];
      if (issue_more) begin
        scan_idx_r <= scan_idx_r + (IDX_W + 1)'(1);
      end
      if (cmp_vld_r && better) begin
        best_r      <= cmp_idx_r;
        best_cost_r <= cost;
        best_occ_r  <= occ;
      end
    end

    if (cmd.commit) begin
      if (cmd_r == nllg_pkg::CMD_RELEASE) begin
        res_gate_r <= rel_r;
        res_pref_r <= 1'b0;
        res_err_r  <= !rel_ok;
      end else begin
        res_gate_r <= nllg_pkg::GATE_W'(best_r);
        res_pref_r <= (best_r == pref_r);
        res_err_r  <= 1'b0;
      end
    end
  end

  assign res_chosen_gate   = res_gate_r;
  assign res_got_preferred = res_pref_r;
  assign res_flag_error    = res_err_r;

endmodule

// ===== rtl/nearest_least_loaded_gate_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Nearest least-loaded gate allocator
// Keeps a per-gate occupancy count and hands out the cheapest gate near a point.
// ----------------------------------------------------------------------------
// The block serves one request at a time. An allocate request is accepted,
// then finds the preferred gate P by stepping a running multiple of the gate
// spacing, then scans the N gates in use through the occupancy RAM's
// registered read port (the scan ends early at the first gate of zero cost),
// and then writes back. A release request passes through accept, RAM read
// and write-back. The result sits in an output register, so the next request
// is accepted while a result still waits; write-back only waits when that
// register is full and not being drained. Occupancy counts live in a RAM
// whose entries carry valid flags that reset clears, so counts read as zero
// after reset without a clearing pass. The gate count is written through
// cfg_wr_en and cfg_wr_data and should only change while the block is idle.
// ----------------------------------------------------------------------------
module nearest_least_loaded_gate_allocator_core #(
  parameter int MAX_GATES    = 16,
  parameter int GATE_SPACING = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] point_distance, [19:16] release_gate, [23:20] zero.
  input  logic [nllg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] cmd: allocate or release.
  input  logic                              in_tuser,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [3:0] chosen_gate, [4] got_preferred, [5] flag_error, [7:6] zero.
  output logic [nllg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Configuration: gate_count.
  input  logic                              cfg_wr_en,
  input  logic [nllg_pkg::CFG_W-1:0]        cfg_wr_data
);

  nllg_pkg::ctrl_cmd_t  cmd;
  nllg_pkg::dp_status_t status;

  logic [nllg_pkg::GATE_W-1:0] res_chosen_gate;
  logic                        res_got_preferred;
  logic                        res_flag_error;

  // The controller walks the request through its phases.
  nllg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the counts, the gate count register and the result.
  nllg_dpath #(
    .MAX_GATES    (MAX_GATES),
    .GATE_SPACING (GATE_SPACING)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_cmd            (in_tuser),
    .in_point_distance (in_tdata[15:0]),
    .in_release_gate   (in_tdata[19:16]),
    .cmd               (cmd),
    .status            (status),
    .res_chosen_gate   (res_chosen_gate),
    .res_got_preferred (res_got_preferred),
    .res_flag_error    (res_flag_error)
  );

  // Pack the result fields from the lowest bit up, padded to a whole byte.
  assign out_tdata = {2'b00, res_flag_error, res_got_preferred, res_chosen_gate};

endmodule

// ===== rtl/nllg_checker.sv =====
// ----------------------------------------------------------------------------
// Gate allocator port checker
// Watches the top-level ports over time and flags inconsistent behavior.
// ----------------------------------------------------------------------------
`include "nearest_least_loaded_gate_allocator_core_macros.svh"

module nllg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [nllg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A held result keeps its valid flag and its payload.
  `NLLG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Requests are served one at a time: an accept closes the input side.
  `NLLG_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

  // A release never reports a preferred gate, an allocate never an error.
  `NLLG_ASSERT_NOW(a_flags_exclusive, out_tvalid, !(out_tdata[4] && out_tdata[5]))

  // A new result appears only at the end of a request in progress.
  `NLLG_ASSERT_NOW(a_result_after_work, $rose(out_tvalid), $past(!in_tready))

endmodule

bind nearest_least_loaded_gate_allocator_core nllg_checker u_nllg_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Gate allocator testbench
// Drives allocate and release requests into the gate allocator, mirrors the
// per-gate occupancy counts in a tracker class, and checks every result word.
// ----------------------------------------------------------------------------
module tb;

  localparam int HALF_PERIOD = 5;
  localparam int GATES       = 16;
  localparam int SPACING     = 48;
  localparam int LONG_HOLD   = 150;

  // One result word, split into its fields.
  typedef struct packed {
    logic [nllg_pkg::GATE_W-1:0] chosen_gate;
    logic                        got_preferred;
    logic                        flag_error;
  } gate_result_t;

  // Mirror of the allocator: its occupancy counts, its gate count, and the
  // results still owed by the block, oldest first.
  class gate_occupancy_tracker;
    logic [nllg_pkg::OCC_W-1:0] occupancy [GATES];
    logic [nllg_pkg::CFG_W-1:0] gate_count;
    gate_result_t               awaited_results [$];
    int                         faults;
    int                         accepted;

    function new();
      foreach (occupancy[g]) occupancy[g] = '0;
      gate_count = 5'd1;
      faults     = 0;
      accepted   = 0;
    endfunction

    // Zero acts as one gate and anything past the array acts as a full array.
    function int unsigned gates_in_use();
      if (gate_count == 0) return 1;
      if (gate_count > GATES) return GATES;
      return gate_count;
    endfunction

    function void set_gate_count(logic [nllg_pkg::CFG_W-1:0] value);
      gate_count = value;
    endfunction

    function void fault(string msg);
      if (faults < 10) $display("%s", msg);
      faults++;
    endfunction

    // Works out the result of one accepted request and updates the counts.
    function void accept_request(logic cmd, logic [nllg_pkg::DIST_W-1:0] point_dist,
                                 logic [nllg_pkg::GATE_W-1:0] rel);
      int unsigned  n;
      int unsigned  pref;
      int unsigned  best;
      int unsigned  best_cost;
      int unsigned  cost;
      int unsigned  span;
      bit           settled;
      gate_result_t r;
      n = gates_in_use();
      r = '0;
      accepted++;
      if (cmd == nllg_pkg::CMD_ALLOC) begin
        pref = (int'(point_dist) + SPACING / 2) / SPACING;
        if (pref > n - 1) pref = n - 1;
        best_cost = 32'hFFFF_FFFF;
        best      = 0;
        settled   = 1'b0;
        // First gate of lowest cost wins; a cost of zero ends the scan.
        for (int unsigned g = 0; g < n && !settled; g++) begin
          span = (g >= pref) ? g - pref : pref - g;
          cost = occupancy[g] + span;
          if (cost < best_cost) begin
            best_cost = cost;
            best      = g;
            settled   = (cost == 0);
          end
        end
        if (occupancy[best] != nllg_pkg::OCC_TOP) occupancy[best]++;
        r.chosen_gate   = best[nllg_pkg::GATE_W-1:0];
        r.got_preferred = (best == pref);
      end else begin
        r.chosen_gate = rel;
        r.flag_error  = 1'b1;
        if (rel < n && occupancy[rel] != 0) begin
          occupancy[rel]--;
          r.flag_error = 1'b0;
        end
      end
      awaited_results.push_back(r);
    endfunction

    function void match_result(logic [nllg_pkg::OUT_TDATA_W-1:0] word);
      gate_result_t got;
      gate_result_t want;
      got.chosen_gate   = word[3:0];
      got.got_preferred = word[4];
      got.flag_error    = word[5];
      if (awaited_results.size() == 0) begin
        fault($sformatf("unexpected result word %h", word));
        return;
      end
      want = awaited_results.pop_front();
      if (got.chosen_gate !== want.chosen_gate ||
          got.got_preferred !== want.got_preferred ||
          got.flag_error !== want.flag_error) begin
        fault($sformatf({"result mismatch: expected gate %0d preferred %0b error %0b,",
                         " got gate %0d preferred %0b error %0b"},
                        want.chosen_gate, want.got_preferred, want.flag_error,
                        got.chosen_gate, got.got_preferred, got.flag_error));
      end
    endfunction

    // Random gate in use that holds at least one agent, so that most
    // releases actually take something back.
    function logic [nllg_pkg::GATE_W-1:0] pick_loaded_gate();
      int unsigned                 n;
      logic [nllg_pkg::GATE_W-1:0] loaded [$];
      n = gates_in_use();
      for (int unsigned g = 0; g < n; g++) begin
        if (occupancy[g] != 0) loaded.push_back(g[nllg_pkg::GATE_W-1:0]);
      end
      if (loaded.size() == 0) return nllg_pkg::GATE_W'($urandom_range(0, GATES - 1));
      return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction
  endclass

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  logic [nllg_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                             in_tuser    = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready  = 1'b0;
  logic [nllg_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_wr_en   = 1'b0;
  logic [nllg_pkg::CFG_W-1:0]       cfg_wr_data = '0;

  gate_occupancy_tracker tracker = new();

  // Random gaps on the request side and random stalls on the result side.
  // Both are switched per phase so that some stretches run without them.
  bit gaps_on  = 1'b0;
  bit stall_on = 1'b0;

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  nearest_least_loaded_gate_allocator_core #(
    .MAX_GATES    (GATES),
    .GATE_SPACING (SPACING)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Offers one request and returns at the edge where it is taken. A gap,
  // when one is drawn, lowers tvalid first.
  task automatic push_request(logic cmd, logic [nllg_pkg::DIST_W-1:0] point_dist,
                              logic [nllg_pkg::GATE_W-1:0] rel);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, rel, point_dist};
    do @(posedge clk); while (!in_tready);
    tracker.accept_request(cmd, point_dist, rel);
  endtask

  // The gate count only changes with the block idle: every owed result has
  // come back, and a pause lets the write-back settle.
  task automatic write_gate_count(logic [nllg_pkg::CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_gate_count(value);
  endtask

  // Distances mostly land on the gates in use, some sit right on the
  // rounding edge between two gates, and the rest span the whole field.
  function automatic logic [nllg_pkg::DIST_W-1:0] pick_distance(int unsigned n);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return nllg_pkg::DIST_W'($urandom_range(0, n * SPACING + SPACING - 1));
      6, 7:             return nllg_pkg::DIST_W'($urandom_range(0, n) * SPACING + SPACING / 2
                                                 - $urandom_range(0, 1));
      default:          return nllg_pkg::DIST_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_phase(logic [nllg_pkg::CFG_W-1:0] cfg, int items, int alloc_pct);
    logic [nllg_pkg::GATE_W-1:0] rel;
    write_gate_count(cfg);
    repeat (items) begin
      if ($urandom_range(1, 100) <= alloc_pct) begin
        push_request(nllg_pkg::CMD_ALLOC, pick_distance(tracker.gates_in_use()),
                     nllg_pkg::GATE_W'($urandom_range(0, GATES - 1)));
      end else begin
        rel = ($urandom_range(0, 3) != 0) ? tracker.pick_loaded_gate()
                                          : nllg_pkg::GATE_W'($urandom_range(0, GATES - 1));
        push_request(nllg_pkg::CMD_RELEASE, nllg_pkg::DIST_W'($urandom_range(0, 65535)), rel);
      end
    end
  endtask

  // Result side. Every accepted word goes to the tracker. Once, early in the
  // long single-gate phase, the receiver holds off for a long stretch so the
  // output register fills and the block pushes back on its requests.
  initial begin : result_sink
    int  stall_left;
    bit  long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.match_result(out_tdata);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_tready <= 1'b1;
      end else if (!long_hold_done && tracker.accepted >= 60) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [nllg_pkg::CFG_W-1:0] phase_counts [10];
    phase_counts = '{5'd16, 5'd8, 5'd17, 5'd0, 5'd31, 5'd3, 5'd12, 5'd2, 5'd16, 5'd1};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stall_on = 1'b1;

    // Single gate from reset: a huge distance clamps to gate zero, and the
    // third release finds the gate empty. Gate fifteen is past the count.
    push_request(nllg_pkg::CMD_ALLOC,   16'd0,     4'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'hFFFF,  4'hF);
    push_request(nllg_pkg::CMD_RELEASE, 16'hFFFF,  4'd0);
    push_request(nllg_pkg::CMD_RELEASE, 16'd0,     4'd0);
    push_request(nllg_pkg::CMD_RELEASE, 16'd0,     4'd0);
    push_request(nllg_pkg::CMD_RELEASE, 16'd0,     4'd15);

    // Full passage: both sides of the rounding edge between gates zero and
    // one, the last gate reached exactly and by clamping, and a crowded
    // last gate that pushes allocations onto its neighbors.
    write_gate_count(5'd16);
    push_request(nllg_pkg::CMD_ALLOC,   16'd0,     4'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'd23,    4'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'd24,    4'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'd47,    4'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'hFFFF,  4'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'd720,   4'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'd744,   4'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'd0,     4'd0);
    push_request(nllg_pkg::CMD_RELEASE, 16'd0,     4'd14);
    push_request(nllg_pkg::CMD_RELEASE, 16'd0,     4'd3);

    // Count above the array acts as sixteen; count zero acts as one, so a
    // loaded gate past it cannot be released.
    write_gate_count(5'd31);
    push_request(nllg_pkg::CMD_ALLOC,   16'hFFFF,  4'd0);
    write_gate_count(5'd0);
    push_request(nllg_pkg::CMD_ALLOC,   16'd400,   4'd0);
    push_request(nllg_pkg::CMD_RELEASE, 16'd0,     4'd15);

    // One gate taking every allocation drives its count into saturation.
    gaps_on = 1'b1;
    random_phase(5'd1, 258, 100);

    // Mixed allocate and release traffic across many gate counts.
    foreach (phase_counts[p]) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      random_phase(phase_counts[p], 22, 55);
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    random_phase(nllg_pkg::CFG_W'($urandom_range(1, 16)), 22, 55);

    // Closing stretch with no gaps and no stalls at all.
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    random_phase(5'd16, 22, 55);

    in_tvalid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.faults == 0 && tracker.awaited_results.size() == 0) begin
      $display("[nearest_least_loaded_gate_allocator_core] OK");
    end else begin
      $display("[nearest_least_loaded_gate_allocator_core] ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #(2 * HALF_PERIOD * 300000);
    $display("[nearest_least_loaded_gate_allocator_core] ERROR");
    $finish;
  end

endmodule
